>>> hdl/hbp_pkg.sv
package hbp_pkg;

   // table geometry and code limits
   localparam int SYMBOLS      = 256;
   localparam int MAX_CODE_LEN = 16;
   localparam int CODE_W       = 16;
   localparam int LEN_W        = 5;
   localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int SYM_ADDR_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

   // pending byte
   localparam int PEND_W  = 7;
   localparam int PCNT_W  = 3;
   localparam int ACC_W   = PEND_W + CODE_W;
   localparam int TOTAL_W = 5;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } entry_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       stream_end;
      logic       last;
   } result_type;

   // up to two results written into the queue in one cycle
   typedef struct packed {
      logic [1:0] n;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

>>> hdl/hbp_ram.sv
module hbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/hbp_pack.sv
module hbp_pack
   import hbp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      s1_valid,
   input  op_type    s1_op,
   input  logic      s1_sym_ok,
   input  entry_type entry,
   output push_type  push
);

   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [PCNT_W-1:0] cnt_ff, cnt_in;

   logic [ACC_W-1:0]   acc;
   logic [TOTAL_W-1:0] total;
   logic [TOTAL_W-1:0] sh0, sh1;
   logic [PCNT_W-1:0]  rem;
   logic [7:0]         byte0, byte1, flush_byte;

   // merge code into the pending bits and cut out finished bytes
   always_comb begin
      acc        = (ACC_W'(pend_ff) << entry.len) | ACC_W'(entry.code);
      total      = TOTAL_W'(cnt_ff) + entry.len;
      sh0        = total - TOTAL_W'(8);
      sh1        = total - TOTAL_W'(16);
      byte0      = 8'(acc >> sh0);
      byte1      = 8'(acc >> sh1);
      rem        = total[PCNT_W-1:0];
      flush_byte = 8'({1'b0, pend_ff} << (4'd8 - {1'b0, cnt_ff}));
   end

   // next pending state and queue writes
   always_comb begin
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      push    = '0;
      if (s1_valid) begin
         unique case (s1_op)
            OP_ENCODE: begin
               if (s1_sym_ok) begin
                  pend_in = PEND_W'(acc) & PEND_W'((8'd1 << rem) - 8'd1);
                  cnt_in  = rem;
                  if (total >= TOTAL_W'(16)) begin
                     push.n  = 2'd2;
                     push.r0 = '{packed_byte: byte0, stream_end: 1'b0, last: 1'b0};
                     push.r1 = '{packed_byte: byte1, stream_end: 1'b0, last: 1'b1};
                  end else if (total >= TOTAL_W'(8)) begin
                     push.n  = 2'd1;
                     push.r0 = '{packed_byte: byte0, stream_end: 1'b0, last: 1'b1};
                  end
               end
            end
            OP_FLUSH: begin
               pend_in = '0;
               cnt_in  = '0;
               push.n  = 2'd1;
               push.r0 = '{packed_byte: flush_byte, stream_end: 1'b1, last: 1'b1};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

   // bits above the pending count stay clear
   a_pend_clean: assert property (@(posedge clock) disable iff (reset)
      (pend_ff >> cnt_ff) == '0)
      else $error("pending bits above count are set");

   // a flush empties the pending byte and always writes one final byte
   a_flush: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && s1_op == OP_FLUSH) |-> (push.n == 2'd1 && push.r0.stream_end)
      ##1 (cnt_ff == '0))
      else $error("flush did not close the stream");

endmodule

>>> hdl/hbp_fifo.sv
module hbp_fifo
   import hbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  push_type              push,
   input  logic                  pop,
   output logic                  not_empty,
   output result_type            head,
   output logic [FIFO_CNT_W-1:0] count
);

   result_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FIFO_PTR_W-1:0] wr_next;

   // pointer and count update
   always_comb begin
      wr_next   = wr_ptr_ff + FIFO_PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      cnt_in    = cnt_ff + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, up to two writes a cycle
   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.n == 2'd2) begin
         mem_ff[wr_next] <= push.r1;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = cnt_ff;

   // writes never overrun the queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cnt_ff} + (FIFO_CNT_W+1)'(push.n)) <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
      else $error("result queue overflow");

   // never read from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("result queue underflow");

   // last entry read with nothing arriving leaves the queue empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == FIFO_CNT_W'(1) && pop && push.n == 2'd0) |=> !not_empty)
      else $error("queue count out of step");

endmodule

>>> hdl/huffman_bit_packer_top.sv
// Huffman bit packer.
// Input channel (req_*): one transaction per item. operation 0 loads the code
// table entry at req_symbol with req_code_bits / req_code_length (length is
// saturated to 16, stray high bits cleared), operation 1 encodes req_symbol,
// operation 2 pads the pending bits with zeros and emits the final byte.
// Result channel (rsp_*): one byte per transaction, earliest code bit in bit 7.
// rsp_last marks the last byte caused by one input; rsp_stream_end marks the
// flush byte. An encode gives zero, one or two bytes, a flush exactly one.
// Path: the table read is registered, then packing writes the result queue,
// whose head is offered on the result channel.
// Throughput: one input per cycle while the result queue has room; the
// one-byte result port sets the sustained rate, so inputs that give two bytes
// cannot be sustained at that rate.
// When the receiver stalls, results collect in an eight-entry queue and
// req_ready drops once it lacks room for the item in flight and a new one.
// Reset empties the queue and clears the pending byte; table entries are
// undefined until loaded. No clearing pass is run after reset.
module huffman_bit_packer_top
   import hbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_symbol,
   input  logic [15:0] req_code_bits,
   input  logic [4:0]  req_code_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_packed_byte,
   output logic        rsp_stream_end,
   output logic        rsp_last
);

   logic      accept;
   logic      sym_ok;
   op_type    op;
   logic      ram_we, ram_re;
   entry_type wr_entry, rd_entry;
   logic [LEN_W-1:0] len_sat;

   logic   s1_valid_ff, s1_valid_in;
   op_type s1_op_ff, s1_op_in;
   logic   s1_ok_ff, s1_ok_in;

   push_type              push;
   result_type            head;
   logic                  q_not_empty;
   logic                  pop;
   logic [FIFO_CNT_W-1:0] q_count;
   logic [FIFO_CNT_W+1:0] q_need;

   // room for the item in flight plus a new one, two bytes each
   always_comb begin
      q_need    = (FIFO_CNT_W+2)'(q_count) + (FIFO_CNT_W+2)'(s1_valid_ff ? 2 : 0)
                  + (FIFO_CNT_W+2)'(2);
      req_ready = (q_need <= (FIFO_CNT_W+2)'(FIFO_DEPTH));
   end

   // decode the input transaction
   always_comb begin
      accept   = req_valid && req_ready;
      op       = op_type'(req_operation);
      sym_ok   = ({1'b0, req_symbol} < 9'(SYMBOLS));
      len_sat  = (req_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : req_code_length;
      wr_entry.len  = len_sat;
      wr_entry.code = req_code_bits & CODE_W'((17'd1 << len_sat) - 17'd1);
      ram_we   = accept && sym_ok && (op == OP_LOAD);
      ram_re   = accept && sym_ok && (op == OP_ENCODE);
      s1_valid_in = accept;
      s1_op_in    = op;
      s1_ok_in    = sym_ok;
   end

   hbp_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SYMBOLS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (req_symbol[SYM_ADDR_W-1:0]),
      .wdata (wr_entry),
      .rdata (rd_entry)
   );

   // stage register alongside the table read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= s1_op_in;
      s1_ok_ff <= s1_ok_in;
   end

   hbp_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid_ff),
      .s1_op     (s1_op_ff),
      .s1_sym_ok (s1_ok_ff),
      .entry     (rd_entry),
      .push      (push)
   );

   assign pop = q_not_empty && rsp_ready;

   hbp_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_valid       = q_not_empty;
   assign rsp_packed_byte = head.packed_byte;
   assign rsp_stream_end  = head.stream_end;
   assign rsp_last        = head.last;

   // an accepted flush always reaches the result queue on the next cycle
   a_flush_pushes: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_FLUSH) |=> (push.n == 2'd1))
      else $error("flush transaction produced no result");

   // loads never produce results
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_LOAD) |=> (push.n == 2'd0))
      else $error("load transaction produced a result");

endmodule

>>> test/tb_huffman_bit_packer_top.sv
module tb_huffman_bit_packer_top;
   import hbp_pkg::*;

   localparam int          CLOCK_PERIOD    = 10;
   localparam int          WATCHDOG_TIME   = 5_000_000;
   localparam int          TAIL_CYCLES     = 10;
   localparam int          RSP_HOLD_CYCLES = 300;
   localparam int          MAX_PRINTED     = 40;
   localparam int          RANDOM_ITEMS    = 1500;
   localparam logic [1:0]  OP_RESERVED     = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [7:0]  req_symbol;
   logic [15:0] req_code_bits;
   logic [4:0]  req_code_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_packed_byte;
   logic        rsp_stream_end;
   logic        rsp_last;

   // predictor state: code table and the partly filled output byte
   logic [CODE_W-1:0] tbl_code   [SYMBOLS];
   logic [LEN_W-1:0]  tbl_len    [SYMBOLS];
   bit                tbl_loaded [SYMBOLS];
   logic [PEND_W-1:0] held_bits;
   int                held_count;

   result_type expected_bytes[$];
   int         error_count;
   int         burst_left;
   bit         hold_request;

   huffman_bit_packer_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_stream_end  (rsp_stream_end),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin : watchdog
      #(WATCHDOG_TIME);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED)
         $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // works out the bytes one accepted transaction should produce
   function automatic void predict_packing(input logic [1:0] op, input logic [7:0] sym,
                                           input logic [15:0] bits, input logic [4:0] len);
      logic [ACC_W-1:0] acc;
      logic [15:0]      padded;
      int               nlen;
      int               total;
      result_type       r;
      case (op)
         OP_LOAD: begin
            if (sym < SYMBOLS) begin
               nlen = (len > LEN_CAP) ? LEN_CAP : int'(len);
               tbl_code[sym]   = CODE_W'(bits & ((32'd1 << nlen) - 1));
               tbl_len[sym]    = LEN_W'(nlen);
               tbl_loaded[sym] = 1'b1;
            end
         end
         OP_ENCODE: begin
            if (sym < SYMBOLS) begin
               nlen  = tbl_len[sym];
               acc   = (ACC_W'(held_bits) << nlen) | ACC_W'(tbl_code[sym]);
               total = held_count + nlen;
               while (total >= 8) begin
                  total         -= 8;
                  r.packed_byte  = 8'(acc >> total);
                  r.stream_end   = 1'b0;
                  r.last         = (total < 8);
                  expected_bytes = {expected_bytes, r};
               end
               held_bits  = PEND_W'(acc & ((32'd1 << total) - 1));
               held_count = total;
            end
         end
         OP_FLUSH: begin
            // zero pad; an empty flush still gives a 0x00 byte
            padded        = 16'(held_bits) << (8 - held_count);
            r.packed_byte = padded[7:0];
            r.stream_end  = 1'b1;
            r.last        = 1'b1;
            expected_bytes = {expected_bytes, r};
            held_bits  = '0;
            held_count = 0;
         end
         default: ;
      endcase
   endfunction

   // offer one transaction and hold it until accepted
   task automatic send_item(input logic [1:0] op, input logic [7:0] sym,
                            input logic [15:0] bits, input logic [4:0] len);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_symbol      <= sym;
      req_code_bits   <= bits;
      req_code_length <= len;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_packing(op, sym, bits, len);
   endtask

   // bursts of random length with random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_drain();
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [4:0] random_length();
      return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(1, 16));
   endfunction

   // edge cases: empty flush, saturation, stray bits, two bytes from one encode
   task automatic test_directed();
      send_item(OP_FLUSH, 8'h00, 16'h0000, 5'd0);
      send_item(OP_LOAD, 8'd0, 16'hFFFF, 5'd16);
      send_item(OP_LOAD, 8'd255, 16'hFFFF, 5'd31);
      send_item(OP_LOAD, 8'd1, 16'hABCD, 5'd0);
      send_item(OP_LOAD, 8'd2, 16'h00FF, 5'd3);
      send_item(OP_LOAD, 8'd3, 16'hFFFE, 5'd1);
      send_item(OP_LOAD, 8'd4, 16'h5A5A, 5'd17);
      send_item(OP_RESERVED, 8'hFF, 16'hFFFF, 5'd31);
      send_item(OP_ENCODE, 8'd1, 16'h0000, 5'd0);
      repeat (7) send_item(OP_ENCODE, 8'd3, 16'h0000, 5'd0);
      // seven bits held plus a 16-bit code: two bytes at once
      send_item(OP_ENCODE, 8'd0, 16'hFFFF, 5'd31);
      send_item(OP_ENCODE, 8'd2, 16'h0000, 5'd0);
      send_item(OP_FLUSH, 8'hFF, 16'hFFFF, 5'd31);
      send_item(OP_ENCODE, 8'd255, 16'h0000, 5'd0);
      send_item(OP_ENCODE, 8'd4, 16'h0000, 5'd0);
      send_item(OP_ENCODE, 8'd2, 16'h0000, 5'd0);
      send_item(OP_FLUSH, 8'h00, 16'h0000, 5'd0);
   endtask

   // load every table entry so that every symbol can be encoded later
   task automatic test_table_fill();
      for (int s = 0; s < SYMBOLS; s++) begin
         pace_sender();
         send_item(OP_LOAD, 8'(s), 16'($urandom), random_length());
      end
   endtask

   // mostly encodes of loaded symbols, with reloads, flushes and noise
   task automatic test_random_traffic(input int count);
      int         pick;
      logic [7:0] sym;
      logic [1:0] op;
      for (int i = 0; i < count; i++) begin
         pace_sender();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            op = OP_LOAD;
         end else if (pick < 14) begin
            op = OP_FLUSH;
         end else if (pick < 16) begin
            op = OP_RESERVED;
         end else begin
            op = OP_ENCODE;
         end
         do sym = 8'($urandom); while (op == OP_ENCODE && !tbl_loaded[sym]);
         send_item(op, sym, 16'($urandom), random_length());
      end
   endtask

   // receiver holds off for a long stretch while encodes keep arriving
   task automatic test_backpressure();
      send_item(OP_LOAD, 8'h5C, 16'($urandom), 5'd16);
      send_item(OP_LOAD, 8'hA3, 16'($urandom), 5'd11);
      hold_request = 1'b1;
      for (int i = 0; i < 80; i++)
         send_item(OP_ENCODE, (i % 2 == 0) ? 8'h5C : 8'hA3, 16'($urandom), 5'($urandom));
      send_item(OP_FLUSH, 8'($urandom), 16'($urandom), 5'($urandom));
      // nothing more is offered until the receiver lets go
      req_valid <= 1'b0;
      do @(posedge clock); while (hold_request);
   endtask

   // sender goes quiet until every pending byte has come out
   task automatic test_drain_pause();
      req_valid <= 1'b0;
      wait_for_drain();
      @(posedge clock);
      test_random_traffic(60);
   endtask

   // compare each result transaction with the oldest expected byte
   always @(posedge clock) begin : byte_checker
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h end %b last %b",
                                      rsp_packed_byte, rsp_stream_end, rsp_last));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_packed_byte !== want.packed_byte)
               report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                         rsp_packed_byte, want.packed_byte));
            if (rsp_stream_end !== want.stream_end)
               report_mismatch($sformatf("stream_end %b, expected %b",
                                         rsp_stream_end, want.stream_end));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
         end
      end
   end

   // receiver stall pattern: stretches of steady, random and periodic ready
   initial begin : rsp_pacer
      int stretch;
      int style;
      int phase;
      rsp_ready <= 1'b0;
      stretch = 0;
      style   = 0;
      phase   = 0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(5, 60);
               style   = $urandom_range(0, 3);
            end
            stretch--;
            phase++;
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (phase % 3 != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= OP_LOAD;
      req_symbol      <= '0;
      req_code_bits   <= '0;
      req_code_length <= '0;
      held_bits        = '0;
      held_count       = 0;
      error_count      = 0;
      burst_left       = 0;
      hold_request     = 1'b0;
      for (int s = 0; s < SYMBOLS; s++) begin
         tbl_code[s]   = '0;
         tbl_len[s]    = '0;
         tbl_loaded[s] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_table_fill();
      test_random_traffic(RANDOM_ITEMS);
      test_backpressure();
      test_drain_pause();

      req_valid <= 1'b0;
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d expected bytes never came", expected_bytes.size()));
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/hbp_pkg.sv
hdl/hbp_ram.sv
hdl/hbp_pack.sv
hdl/hbp_fifo.sv
hdl/huffman_bit_packer_top.sv
test/tb_huffman_bit_packer_top.sv
